// ===== design/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the request framer checks.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

// ===== design/mrf_pkg.sv =====
// ----------------------------------------------------------------------------
// mrf_pkg
// Types, frame constants and the CRC-16 byte step for the request framer.
// ----------------------------------------------------------------------------
package mrf_pkg;

    localparam logic [7:0]  SLAVE_ADDR        = 8'h01;
    localparam logic [7:0]  FUNC_READ_HOLDING = 8'h03;
    localparam logic [15:0] CRC_INIT          = 16'hFFFF;
    localparam logic [15:0] CRC_POLY          = 16'hA001;

    // Position of a byte within the eight-byte frame, in transmit order.
    typedef enum logic [2:0] {
        POS_SLAVE    = 3'd0,
        POS_FUNC     = 3'd1,
        POS_ADDR_HI  = 3'd2,
        POS_ADDR_LO  = 3'd3,
        POS_COUNT_HI = 3'd4,
        POS_COUNT_LO = 3'd5,
        POS_CRC_LO   = 3'd6,
        POS_CRC_HI   = 3'd7
    } byte_pos_t;

    // Request fields plus the running CRC as they travel down the pipeline.
    typedef struct packed {
        logic [15:0] register_address;
        logic [15:0] register_count;
        logic [15:0] crc;
    } stage_t;

    // One byte of the reflected Modbus CRC-16: eight shift/xor steps.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // The slave address and function code never change, so the CRC over
    // them is settled at elaboration.
    localparam logic [15:0] CRC_HDR = crc_byte(crc_byte(CRC_INIT, SLAVE_ADDR),
                                               FUNC_READ_HOLDING);

endpackage

// ===== design/mrf_req_if.sv =====
// ----------------------------------------------------------------------------
// mrf_req_if
// Valid/ready channel carrying one read request item.
// ----------------------------------------------------------------------------
interface mrf_req_if;
    logic        valid;
    logic        ready;
    logic [15:0] register_address;
    logic [15:0] register_count;

    modport source (output valid, output register_address, output register_count,
                    input ready);
    modport sink   (input valid, input register_address, input register_count,
                    output ready);
endinterface

// ===== design/mrf_byte_if.sv =====
// ----------------------------------------------------------------------------
// mrf_byte_if
// Valid/ready channel carrying one frame byte item with a last-byte flag.
// ----------------------------------------------------------------------------
interface mrf_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       is_last;

    modport source (output valid, output frame_byte, output is_last, input ready);
    modport sink   (input valid, input frame_byte, input is_last, output ready);
endinterface

// ===== design/modbus_read_request_framer.sv =====
// ----------------------------------------------------------------------------
// modbus_read_request_framer
// Builds Modbus RTU read-holding-registers request frames with CRC-16.
// ----------------------------------------------------------------------------
// Each request item (start register address, register count) turns into the
// eight-byte frame 01 03 addr_hi addr_lo count_hi count_lo crc_lo crc_hi,
// sent as eight byte items with is_last set on the CRC high byte. Every
// address and count value is framed as given. The CRC over the constant
// slave address and function code is precomputed; four register stages then
// fold in one header byte each, eight CRC bit steps per stage. A request is
// accepted in any cycle a stage has room, so up to four requests sit in the
// CRC pipeline while a fifth is being sent. An accepted request passes the
// four CRC stage registers into the serializer, which then offers the first
// frame byte. The output serializer sets the sustained throughput and sends
// one byte per cycle while the output is ready; the next frame follows the
// last byte of the previous one with no gap. Output stalls hold the byte steady.
// ----------------------------------------------------------------------------
module modbus_read_request_framer (
    input  logic        clk,
    input  logic        rst_n,
    mrf_req_if.sink     req,
    mrf_byte_if.source  frame
);

    localparam int NUM_STAGES = 4;

    logic            stg_valid [NUM_STAGES+1];
    logic            stg_ready [NUM_STAGES+1];
    mrf_pkg::stage_t stg_data  [NUM_STAGES+1];
    logic [7:0]      stg_byte  [NUM_STAGES];

    // Stage input: request fields with the CRC already past the fixed header.
    assign stg_valid[0]                 = req.valid;
    assign req.ready                    = stg_ready[0];
    assign stg_data[0].register_address = req.register_address;
    assign stg_data[0].register_count   = req.register_count;
    assign stg_data[0].crc              = mrf_pkg::CRC_HDR;

    // Each stage absorbs the next header byte in transmit order.
    assign stg_byte[0] = stg_data[0].register_address[15:8];
    assign stg_byte[1] = stg_data[1].register_address[7:0];
    assign stg_byte[2] = stg_data[2].register_count[15:8];
    assign stg_byte[3] = stg_data[3].register_count[7:0];

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_crc
        mrf_crc_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[i]),
            .in_ready  (stg_ready[i]),
            .in_data   (stg_data[i]),
            .in_byte   (stg_byte[i]),
            .out_valid (stg_valid[i+1]),
            .out_ready (stg_ready[i+1]),
            .out_data  (stg_data[i+1])
        );
    end

    mrf_serializer u_ser (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (stg_valid[NUM_STAGES]),
        .in_ready (stg_ready[NUM_STAGES]),
        .in_data  (stg_data[NUM_STAGES]),
        .frame    (frame)
    );

endmodule

// ===== design/mrf_crc_stage.sv =====
// ----------------------------------------------------------------------------
// mrf_crc_stage
// One elastic pipeline stage that folds one frame byte into the CRC.
// ----------------------------------------------------------------------------
module mrf_crc_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  mrf_pkg::stage_t in_data,
    input  logic [7:0]      in_byte,
    output logic            out_valid,
    input  logic            out_ready,
    output mrf_pkg::stage_t out_data
);

    logic            valid_reg;
    mrf_pkg::stage_t data_reg;
    mrf_pkg::stage_t data_next;

    // The stage takes a new item whenever it is empty or its item moves on.
    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        data_next     = in_data;
        data_next.crc = mrf_pkg::crc_byte(in_data.crc, in_byte);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// ===== design/mrf_serializer.sv =====
// ----------------------------------------------------------------------------
// mrf_serializer
// Holds one finished request and sends its eight frame bytes in order.
// ----------------------------------------------------------------------------
module mrf_serializer (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mrf_pkg::stage_t   in_data,
    mrf_byte_if.source        frame
);

    logic               busy_reg;
    mrf_pkg::byte_pos_t pos_reg;
    mrf_pkg::stage_t    hold_reg;
    logic               byte_taken;
    logic               frame_done;

    assign byte_taken = busy_reg && frame.ready;
    assign frame_done = byte_taken && (pos_reg == mrf_pkg::POS_CRC_HI);

    // A new request loads in the same cycle the last byte of the old one leaves.
    assign in_ready = !busy_reg || frame_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            pos_reg  <= mrf_pkg::POS_SLAVE;
        end
        else if (in_ready)
        begin
            busy_reg <= in_valid;
            pos_reg  <= mrf_pkg::POS_SLAVE;
        end
        else if (byte_taken)
        begin
            pos_reg <= mrf_pkg::byte_pos_t'(pos_reg + 3'd1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            hold_reg <= in_data;
        end
    end

    always_comb
    begin
        case (pos_reg)
            mrf_pkg::POS_SLAVE:    frame.frame_byte = mrf_pkg::SLAVE_ADDR;
            mrf_pkg::POS_FUNC:     frame.frame_byte = mrf_pkg::FUNC_READ_HOLDING;
            mrf_pkg::POS_ADDR_HI:  frame.frame_byte = hold_reg.register_address[15:8];
            mrf_pkg::POS_ADDR_LO:  frame.frame_byte = hold_reg.register_address[7:0];
            mrf_pkg::POS_COUNT_HI: frame.frame_byte = hold_reg.register_count[15:8];
            mrf_pkg::POS_COUNT_LO: frame.frame_byte = hold_reg.register_count[7:0];
            mrf_pkg::POS_CRC_LO:   frame.frame_byte = hold_reg.crc[7:0];
            mrf_pkg::POS_CRC_HI:   frame.frame_byte = hold_reg.crc[15:8];
            default:               frame.frame_byte = mrf_pkg::SLAVE_ADDR;
        endcase
    end

    assign frame.valid   = busy_reg;
    assign frame.is_last = (pos_reg == mrf_pkg::POS_CRC_HI);

endmodule

// ===== design/mrf_checker.sv =====
// ----------------------------------------------------------------------------
// mrf_checker
// Port-level checks on the frame output of the request framer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mrf_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic [2:0] count_reg;
    logic       taken;

    assign taken = out_valid && out_ready;

    // Position of the next byte within its frame, from delivered bytes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= 3'd0;
        end
        else if (taken)
        begin
            count_reg <= count_reg + 3'd1;
        end
    end

    `ASSERT_NEXT(a_hold_stall, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last))
    `ASSERT_IMPLY(a_last_pos, clk, rst_n, out_valid, out_last == (count_reg == 3'd7))
    `ASSERT_IMPLY(a_slave_byte, clk, rst_n, out_valid && count_reg == 3'd0, out_byte == mrf_pkg::SLAVE_ADDR)
    `ASSERT_IMPLY(a_func_byte, clk, rst_n, out_valid && count_reg == 3'd1, out_byte == mrf_pkg::FUNC_READ_HOLDING)

endmodule

bind modbus_read_request_framer mrf_checker u_mrf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (frame.valid),
    .out_ready (frame.ready),
    .out_byte  (frame.frame_byte),
    .out_last  (frame.is_last)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Modbus RTU read request framer. Read requests
// go in on a valid/ready channel. Every frame byte that comes out is compared
// with a frame computed here, which holds the header bytes and the CRC-16.
// Both sides of the block stall at random, and one long hold on the output
// fills the pipeline.
// ----------------------------------------------------------------------------
module testbench;

    // ------------------------------------------------------------------------
    // Run shape
    // ------------------------------------------------------------------------
    localparam int IDLE_PERCENT    = 30;    // chance of a gap or a stall per cycle
    localparam int RANDOM_REQUESTS = 300;
    localparam int CALM_FROM       = 150;   // no gaps or stalls in this request range
    localparam int CALM_TO         = 220;
    localparam int HOLD_AT         = 60;    // the long output hold starts here
    localparam int HOLD_CYCLES     = 150;
    localparam int DRAIN_CYCLES    = 20;    // time left for stray bytes once nothing is owed
    localparam int QUIET_LIMIT     = 2000;  // cycles with no handshake on either side
    localparam int DIRECTED_COUNT  = 14;

    // One directed request. Where has_crc is set, the CRC is typed in from
    // well-known example frames, and the CRC is not taken from the
    // predictor. It is stored as sent: the low byte goes out first.
    typedef struct packed {
        logic [15:0] address;
        logic [15:0] count;
        logic        has_crc;
        logic [15:0] crc;
    } request_row_t;

    // One frame byte as it should appear on the output channel.
    typedef struct packed {
        logic [7:0] frame_byte;
        logic       is_last;
    } frame_byte_t;

    logic clk = 1'b0;
    logic rst_n;

    mrf_req_if  req_ch ();
    mrf_byte_if frame_ch ();

    modbus_read_request_framer dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .frame (frame_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Frame bytes still owed by the block, oldest first.
    frame_byte_t bytes_due [$];

    int requests_taken = 0;
    int bytes_checked  = 0;
    int failures       = 0;
    int quiet_cycles   = 0;

    // The directed table. It covers the field extremes, alternating bit
    // patterns, a single set top bit in each field, and a zero count.
    // The two known frames are 01 03 00 00 00 01 84 0A and
    // 01 03 00 00 00 0A C5 CD.
    request_row_t directed_rows [DIRECTED_COUNT] = '{
        '{16'h0000, 16'h0001, 1'b1, 16'h0A84},
        '{16'h0000, 16'h000A, 1'b1, 16'hCDC5},
        '{16'h0000, 16'h0000, 1'b0, 16'h0000},
        '{16'hFFFF, 16'hFFFF, 1'b0, 16'h0000},
        '{16'h0000, 16'hFFFF, 1'b0, 16'h0000},
        '{16'hFFFF, 16'h0000, 1'b0, 16'h0000},
        '{16'h5555, 16'hAAAA, 1'b0, 16'h0000},
        '{16'hAAAA, 16'h5555, 1'b0, 16'h0000},
        '{16'h00FF, 16'hFF00, 1'b0, 16'h0000},
        '{16'hFF00, 16'h00FF, 1'b0, 16'h0000},
        '{16'h8000, 16'h0001, 1'b0, 16'h0000},
        '{16'h0001, 16'h8000, 1'b0, 16'h0000},
        '{16'h0000, 16'h007D, 1'b0, 16'h0000},
        '{16'hFFFE, 16'h007E, 1'b0, 16'h0000}
    };

    // Inside the calm stretch neither side idles, so the block runs at its
    // full rate of one request per eight output bytes.
    function automatic logic in_calm_stretch();
        return (requests_taken >= CALM_FROM) && (requests_taken < CALM_TO);
    endfunction

    // Modbus CRC-16 over the six header bytes. The CRC is reflected: each
    // byte is folded into the low end, and the register is shifted right eight
    // times. On each shift the polynomial is xored in when a one falls out.
    function automatic logic [15:0] request_crc(input logic [15:0] address,
                                                input logic [15:0] count);
        logic [47:0] header;
        logic [15:0] crc;
        header = {mrf_pkg::SLAVE_ADDR, mrf_pkg::FUNC_READ_HOLDING, address, count};
        crc = mrf_pkg::CRC_INIT;
        for (int i = 5; i >= 0; i--)
        begin
            crc = crc ^ {8'h00, header[i*8 +: 8]};
            for (int b = 0; b < 8; b++)
            begin
                crc = crc[0] ? ((crc >> 1) ^ mrf_pkg::CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

    // Queue the eight bytes that one accepted request must produce, in
    // transmit order: the header, then the CRC low byte and the CRC high byte.
    task automatic queue_frame(input logic [15:0] address, input logic [15:0] count,
                               input logic has_crc, input logic [15:0] typed_crc);
        logic [15:0] crc;
        logic [63:0] frame_bits;
        frame_byte_t entry;
        crc = has_crc ? typed_crc : request_crc(address, count);
        frame_bits = {mrf_pkg::SLAVE_ADDR, mrf_pkg::FUNC_READ_HOLDING, address, count,
                      crc[7:0], crc[15:8]};
        for (int k = 0; k < 8; k++)
        begin
            entry.frame_byte = frame_bits[(7 - k)*8 +: 8];
            entry.is_last    = (mrf_pkg::byte_pos_t'(k) == mrf_pkg::POS_CRC_HI);
            bytes_due.push_back(entry);
        end
    endtask

    // Offer one request and hold it until the block takes it. Outside the
    // calm stretch, a random gap with valid low may come first. Valid is only
    // lowered when a gap follows, so a request that comes right after the
    // previous one sees valid stay high with no glitch.
    task automatic offer_request(input logic [15:0] address, input logic [15:0] count,
                                 input logic has_crc, input logic [15:0] typed_crc);
        if (!in_calm_stretch() && ($urandom_range(0, 99) < IDLE_PERCENT))
        begin
            req_ch.valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(0, 99) < IDLE_PERCENT);
        end
        req_ch.valid            <= 1'b1;
        req_ch.register_address <= address;
        req_ch.register_count   <= count;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        // Accepted at this edge, so the frame is now owed.
        queue_frame(address, count, has_crc, typed_crc);
        requests_taken++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: ready drops at random. It stays high through the calm
    // stretch, and once it is held low for a long run while the sender keeps
    // offering requests. That fills the CRC pipeline and must stall the input.
    // ------------------------------------------------------------------------
    initial
    begin
        logic held_off;
        held_off = 1'b0;
        frame_ch.ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (!held_off && requests_taken >= HOLD_AT)
            begin
                held_off = 1'b1;
                frame_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                frame_ch.ready <= in_calm_stretch() ||
                                  ($urandom_range(0, 99) >= IDLE_PERCENT);
                @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Output check. Every accepted byte must match the oldest byte still owed,
    // field by field. Values are read at the edge, so they are the ones that
    // the handshake moved.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        frame_byte_t due;
        if (rst_n && frame_ch.valid && frame_ch.ready)
        begin
            bytes_checked++;
            if (bytes_due.size() == 0)
            begin
                $error("frame byte %h arrived with no frame owed", frame_ch.frame_byte);
                failures++;
            end
            else
            begin
                due = bytes_due.pop_front();
                if (frame_ch.frame_byte !== due.frame_byte)
                begin
                    $error("frame_byte: expected %h, got %h",
                           due.frame_byte, frame_ch.frame_byte);
                    failures++;
                end
                if (frame_ch.is_last !== due.is_last)
                begin
                    $error("is_last: expected %b, got %b", due.is_last, frame_ch.is_last);
                    failures++;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: a hung handshake ends the run. The limit is far above the
    // longest correct stretch with no handshake, which is the long hold.
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((req_ch.valid && req_ch.ready) || (frame_ch.valid && frame_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("Timed out after %0d cycles with no handshake.", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Main sequence: reset, the directed table, then random requests.
    // ------------------------------------------------------------------------
    initial
    begin
        logic [15:0] address;
        logic [15:0] count;
        int          pick;

        rst_n                   <= 1'b0;
        req_ch.valid            <= 1'b0;
        req_ch.register_address <= '0;
        req_ch.register_count   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < DIRECTED_COUNT; r++)
        begin
            offer_request(directed_rows[r].address, directed_rows[r].count,
                          directed_rows[r].has_crc, directed_rows[r].crc);
        end

        // The largest share of random requests is what a real host sends: a random
        // start address with a count in the usual 1 to 125 range. Fully
        // random fields and corner values (zero, all ones, one set bit)
        // are mixed in.
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
            begin
                address = 16'($urandom_range(0, 16'hFFFF));
                count   = 16'($urandom_range(1, 125));
            end
            else if (pick < 85)
            begin
                address = 16'($urandom_range(0, 16'hFFFF));
                count   = 16'($urandom_range(0, 16'hFFFF));
            end
            else
            begin
                case ($urandom_range(0, 2))
                    0:       address = 16'h0000;
                    1:       address = 16'hFFFF;
                    default: address = 16'h0001 << $urandom_range(0, 15);
                endcase
                case ($urandom_range(0, 2))
                    0:       count = 16'h0000;
                    1:       count = 16'hFFFF;
                    default: count = 16'h0001 << $urandom_range(0, 15);
                endcase
            end
            offer_request(address, count, 1'b0, 16'h0000);
        end
        req_ch.valid <= 1'b0;

        // Wait for every owed byte, then allow time for any stray bytes.
        while (bytes_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (bytes_due.size() != 0)
        begin
            $error("%0d frame bytes never arrived", bytes_due.size());
            failures++;
        end

        $display("Framed %0d read requests (%0d from the table, %0d random); %0d bytes checked.",
                 requests_taken, DIRECTED_COUNT, RANDOM_REQUESTS, bytes_checked);
        $display("Random gaps on both sides, one %0d-cycle output hold; %0d mismatches.",
                 HOLD_CYCLES, failures);
        if (failures == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+design
design/mrf_pkg.sv
design/mrf_req_if.sv
design/mrf_byte_if.sv
design/mrf_crc_stage.sv
design/mrf_serializer.sv
design/modbus_read_request_framer.sv
design/mrf_checker.sv
sim/testbench.sv
